>>> rtl/core/hnr_pkg.sv
// ----------------------------------------------------------------------------
// hnr_pkg
// Shared types, widths and bit-shuffle helpers of the nested/ring converter.
// ----------------------------------------------------------------------------
package hnr_pkg;

    localparam int MAX_ORDER = 13;
    localparam int ORD_W     = 4;
    localparam int PIX_W     = 30;
    localparam int CRD_W     = MAX_ORDER;
    localparam int PAIR_W    = 2 * CRD_W;
    localparam int SC_W      = MAX_ORDER + 6;
    localparam int WIDE_W    = 32;
    localparam int PROD_W    = 2 * MAX_ORDER;
    localparam int SQ_W      = 30;
    localparam int SQ_STEPS  = SQ_W / 2;

    localparam int PADDR_W   = 3;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_NSIDE_LOG2 = '0;
    localparam logic [ORD_W-1:0]     NSIDE_LOG2_RST = ORD_W'(10);

    localparam logic [1:0] Z_NORTH = 2'd0;
    localparam logic [1:0] Z_EQU   = 2'd1;
    localparam logic [1:0] Z_SOUTH = 2'd2;

    typedef logic signed [SC_W-1:0]   t_sc;
    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel_in;
    } t_req;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             error;
    } t_rsp;

    // Per-item state carried down the pipeline
    typedef struct packed {
        logic              op;
        logic              err;
        logic [1:0]        zone;
        logic [PIX_W-1:0]  v;
        logic [3:0]        bh;
        t_sc               x;
        t_sc               y;
        t_sc               ring;
        t_sc               d;
        t_sc               lon;
        logic              wrap;
        logic              eq;
        logic [PROD_W-1:0] prod;
        t_wide             res;
    } t_car;

    function automatic logic [CRD_W-1:0] unshuffle(input logic [PAIR_W-1:0] v,
                                                   input logic odd);
        logic [CRD_W-1:0] r;
        for (int i = 0; i < CRD_W; i++) begin
            r[i] = odd ? v[2*i+1] : v[2*i];
        end
        return r;
    endfunction

    function automatic logic [PAIR_W-1:0] shuffle(input logic [CRD_W-1:0] x,
                                                  input logic [CRD_W-1:0] y);
        logic [PAIR_W-1:0] m;
        for (int i = 0; i < CRD_W; i++) begin
            m[2*i]   = x[i];
            m[2*i+1] = y[i];
        end
        return m;
    endfunction

    // Halve, rounding toward zero
    function automatic t_sc div2t(input t_sc v);
        t_sc s;
        s = v + t_sc'(v[SC_W-1]);
        return s >>> 1;
    endfunction

endpackage

>>> rtl/core/healpix_nest_ring_converter.sv
// ----------------------------------------------------------------------------
// healpix_nest_ring_converter
// Converts pixel numbers between the NESTED and RING schemes, both ways.
// ----------------------------------------------------------------------------
// Throughput one request per cycle unless the result is stalled. The depth of
// the pipeline comes from the 15-stage pipelined square root that locates the
// polar cap ring. A stalled result freezes every stage in place.
// Reset (synchronous, active low) clears all valid bits and sets nside_log2
// to 10.
// ----------------------------------------------------------------------------
module healpix_nest_ring_converter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  hnr_pkg::t_req                   i_req,
    output logic                            o_valid,
    input  logic                            i_ready,
    output hnr_pkg::t_rsp                   o_rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hnr_pkg::PADDR_W-1:0]     paddr,
    input  logic [hnr_pkg::DATA_W-1:0]      pwdata,
    output logic [hnr_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import hnr_pkg::*;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [ORD_W-1:0] r_nside_log2;
    logic             reg_hit;

    assign reg_hit = (paddr[PADDR_W-1:2] == REG_NSIDE_LOG2);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? DATA_W'(r_nside_log2) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nside_log2 <= NSIDE_LOG2_RST;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_nside_log2 <= pwdata[ORD_W-1:0];
        end
    end

    // Order geometry; user keeps it stable with requests in flight, unchecked
    logic [ORD_W-1:0] ord;
    logic [ORD_W:0]   ord2;
    t_sc              ns, ns3, ns4;
    t_wide            npix, ncap, eqend;

    assign ord   = (r_nside_log2 > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : r_nside_log2;
    assign ord2  = {ord, 1'b0};
    assign ns    = t_sc'(1) <<< ord;
    assign ns4   = ns <<< 2;
    assign ns3   = ns4 - ns;
    assign npix  = t_wide'(12) <<< ord2;
    assign ncap  = (t_wide'(2) <<< ord2) - (t_wide'(ns) <<< 1);
    assign eqend = ncap + (t_wide'(8) <<< ord2);

    // ------------------------------------------------------------------
    // Flow control: the whole pipe advances unless the result is stuck
    // ------------------------------------------------------------------
    logic adv;
    logic r_out_vld;
    t_rsp r_rsp;

    assign adv     = !r_out_vld || i_ready;
    assign o_ready = adv;
    assign o_valid = r_out_vld;
    assign o_rsp   = r_rsp;

    // ------------------------------------------------------------------
    // Prep: range check, face split, region of the ring walk, sqrt operand
    // ------------------------------------------------------------------
    t_car              n_pc;
    t_wide             p_w, q_w;
    logic [PAIR_W-1:0] low;
    logic [PIX_W-1:0]  v_sel;
    t_sc               ring_n;

    assign p_w = t_wide'({2'b00, i_req.pixel_in});
    assign q_w = p_w - ncap;

    always_comb begin
        n_pc      = '0;
        n_pc.op   = i_req.op;
        n_pc.bh   = 4'(i_req.pixel_in >> ord2);
        low       = PAIR_W'(i_req.pixel_in) & ((PAIR_W'(1) << ord2) - PAIR_W'(1));
        n_pc.x    = t_sc'(unshuffle(low, 1'b0));
        n_pc.y    = t_sc'(unshuffle(low, 1'b1));
        ring_n    = ((t_sc'(n_pc.bh[3:2]) + 2) <<< ord) - n_pc.x - n_pc.y - 1;

        if (p_w < ncap) begin
            n_pc.zone = Z_NORTH;
        end else if (p_w < eqend) begin
            n_pc.zone = Z_EQU;
        end else begin
            n_pc.zone = Z_SOUTH;
        end

        // Drop to error on out-of-range pixel or an impossible ring
        n_pc.err = (p_w >= npix) || (!i_req.op && (ring_n < 1 || ring_n >= ns4));

        // Belt rings come straight from the offset; caps wait for the sqrt
        n_pc.ring = i_req.op ? ns + t_sc'(q_w >>> (ord + 2)) : ring_n;
        n_pc.lon  = t_sc'(q_w & (t_wide'(ns4) - 1));

        v_sel  = (n_pc.zone == Z_NORTH) ? i_req.pixel_in
                                        : PIX_W'(npix - 1 - p_w);
        n_pc.v = v_sel;
    end

    // ------------------------------------------------------------------
    // Integer square root of 2v+1, one result bit per stage
    // ------------------------------------------------------------------
    logic [SQ_W-1:0] r_sq_rem  [0:SQ_STEPS];
    logic [SQ_W-1:0] r_sq_root [0:SQ_STEPS];
    t_car            r_sq_car  [0:SQ_STEPS];
    logic            r_sq_vld  [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (adv) begin
            r_sq_vld[0] <= i_valid;
        end
        if (adv) begin
            r_sq_car[0]  <= n_pc;
            r_sq_rem[0]  <= {v_sel[SQ_W-2:0], 1'b1};
            r_sq_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        logic [SQ_W-1:0] trial, n_rem, n_root;

        always_comb begin
            trial = r_sq_root[k] + BITV;
            if (r_sq_rem[k] >= trial) begin
                n_rem  = r_sq_rem[k] - trial;
                n_root = (r_sq_root[k] >> 1) + BITV;
            end else begin
                n_rem  = r_sq_rem[k];
                n_root = r_sq_root[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (adv) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
            if (adv) begin
                r_sq_rem[k+1]  <= n_rem;
                r_sq_root[k+1] <= n_root;
                r_sq_car[k+1]  <= r_sq_car[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Ring from the root, distance to the nearer pole, and d*(d-1)
    // ------------------------------------------------------------------
    t_car                 r_rc, n_rc;
    logic                 r_rc_vld;
    t_sc                  rc;
    logic [MAX_ORDER:0]   du;

    always_comb begin
        n_rc = r_sq_car[SQ_STEPS];
        rc   = t_sc'((r_sq_root[SQ_STEPS] + 1'b1) >> 1);
        if (n_rc.op) begin
            case (n_rc.zone)
                Z_NORTH: n_rc.ring = rc;
                Z_SOUTH: n_rc.ring = ns4 - rc;
                default: n_rc.ring = r_sq_car[SQ_STEPS].ring;
            endcase
        end
        n_rc.d    = (n_rc.ring <= ns) ? n_rc.ring : ns4 - n_rc.ring;
        du        = n_rc.d[MAX_ORDER:0];
        n_rc.prod = PROD_W'(du) * PROD_W'(du - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc_vld <= 1'b0;
        end else if (adv) begin
            r_rc_vld <= r_sq_vld[SQ_STEPS];
        end
        if (adv) begin
            r_rc <= n_rc;
        end
    end

    // ------------------------------------------------------------------
    // In-ring index (ring to nested), full ring pixel (nested to ring)
    // ------------------------------------------------------------------
    t_car  r_lc, n_lc;
    logic  r_lc_vld;
    t_wide tp, vw, bm, idr;
    t_sc   f2l, tl2;
    logic  sbl;

    always_comb begin
        n_lc = r_rc;
        tp   = t_wide'(r_rc.prod) <<< 1;
        vw   = t_wide'({2'b00, r_rc.v});
        bm   = t_wide'(r_rc.bh[1:0]);
        idr  = '0;
        sbl  = r_rc.ring[0] ^ ns[0];
        f2l  = (t_sc'(r_rc.bh[1:0]) <<< 1) - t_sc'(r_rc.bh[2]) + 1;
        tl2  = (f2l <<< ord) + r_rc.x - r_rc.y + t_sc'(sbl);
        if (r_rc.op) begin
            case (r_rc.zone)
                Z_NORTH: n_lc.lon = t_sc'(vw - tp);
                Z_SOUTH: n_lc.lon = t_sc'((t_wide'(r_rc.d) <<< 2) - 1 - (vw - tp));
                default: n_lc.lon = r_rc.lon;
            endcase
        end else if (r_rc.ring <= ns) begin
            n_lc.res = t_wide'(ns) - 1 - t_wide'(r_rc.y) + bm * t_wide'(r_rc.ring) + tp;
        end else if (r_rc.ring >= ns3) begin
            idr = t_wide'(r_rc.d) - 1 - t_wide'(r_rc.x) + (3 - bm) * t_wide'(r_rc.d) + tp;
            n_lc.res = npix - 1 - idr;
        end else begin
            // Belt: add 4*nside-1 for the face straddling longitude zero
            n_lc.res = t_wide'(div2t(tl2)) + ncap
                     + (t_wide'(r_rc.ring - ns) <<< (ord + 2))
                     + ((r_rc.bh == 4'd4 && r_rc.y > r_rc.x) ? t_wide'(ns4) - 1 : t_wide'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc_vld <= 1'b0;
        end else if (adv) begin
            r_lc_vld <= r_rc_vld;
        end
        if (adv) begin
            r_lc <= n_lc;
        end
    end

    // ------------------------------------------------------------------
    // Face and coordinates: caps finish here, belt picks face and wrap
    // ------------------------------------------------------------------
    t_car       r_qc, n_qc;
    logic       r_qc_vld;
    t_sc        d2, d3, qd, rem, ind;
    logic [1:0] qt, panel;
    logic       bl, tlf;

    always_comb begin
        n_qc  = r_lc;
        d2    = r_lc.d <<< 1;
        d3    = d2 + r_lc.d;
        if (r_lc.lon >= d3) begin
            qt = 2'd3;
            qd = d3;
        end else if (r_lc.lon >= d2) begin
            qt = 2'd2;
            qd = d2;
        end else if (r_lc.lon >= r_lc.d) begin
            qt = 2'd1;
            qd = r_lc.d;
        end else begin
            qt = 2'd0;
            qd = '0;
        end
        rem   = r_lc.lon - qd;
        panel = 2'(r_lc.lon >>> ord);
        ind   = r_lc.lon & (ns - 1);
        bl    = ind < ((r_lc.ring - ns + 1) >>> 1);
        tlf   = ind < ((ns3 - r_lc.ring + 1) >>> 1);
        if (r_lc.op) begin
            n_qc.eq   = 1'b0;
            n_qc.wrap = 1'b0;
            if (r_lc.ring <= ns) begin
                n_qc.bh = {2'b00, qt};
                n_qc.y  = ns - 1 - rem;
                n_qc.x  = (ns <<< 1) - r_lc.ring - 1 - n_qc.y;
            end else if (r_lc.ring >= ns3) begin
                n_qc.bh = {2'b10, qt};
                n_qc.y  = r_lc.d - 1 - rem;
                n_qc.x  = rem;
            end else begin
                n_qc.eq = 1'b1;
                if (!bl && tlf) begin
                    n_qc.bh = {2'b00, panel};
                end else if (bl && !tlf) begin
                    n_qc.bh = {2'b10, panel};
                end else if (bl && tlf) begin
                    n_qc.bh = {2'b01, panel};
                end else begin
                    n_qc.bh = {2'b01, panel + 2'd1};
                    if (panel == 2'd3) begin
                        n_qc.lon  = r_lc.lon - (ns4 - 1);
                        n_qc.wrap = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qc_vld <= 1'b0;
        end else if (adv) begin
            r_qc_vld <= r_lc_vld;
        end
        if (adv) begin
            r_qc <= n_qc;
        end
    end

    // ------------------------------------------------------------------
    // Belt x,y from vertical and horizontal offsets, with parity fix
    // ------------------------------------------------------------------
    t_car r_ec, n_ec;
    logic r_ec_vld;
    t_sc  f2e, vv, hh, h1, x0, y0, x1, y1;
    logic sbe;

    always_comb begin
        n_ec = r_qc;
        sbe  = r_qc.ring[0] ^ ns[0];
        f2e  = (t_sc'(r_qc.bh[1:0]) <<< 1) - t_sc'(r_qc.bh[2]) + 1;
        vv   = ((t_sc'(r_qc.bh[3:2]) + 2) <<< ord) - r_qc.ring - 1;
        hh   = (r_qc.lon <<< 1) - t_sc'(sbe) - (f2e <<< ord) - t_sc'(r_qc.wrap);
        h1   = hh + 1;
        x0   = div2t(vv + hh);
        y0   = div2t(vv - hh);
        x1   = div2t(vv + h1);
        y1   = div2t(vv - h1);
        if (r_qc.op && r_qc.eq) begin
            if (vv != x0 + y0 || hh != x0 - y0) begin
                n_ec.x = x1;
                n_ec.y = y1;
            end else begin
                n_ec.x = x0;
                n_ec.y = y0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ec_vld <= 1'b0;
        end else if (adv) begin
            r_ec_vld <= r_qc_vld;
        end
        if (adv) begin
            r_ec <= n_ec;
        end
    end

    // ------------------------------------------------------------------
    // Output: re-interleave, final range check, hold until taken
    // ------------------------------------------------------------------
    t_rsp              n_rsp;
    t_wide             res_f;
    logic              bad, err_f;
    logic [PAIR_W-1:0] m;

    always_comb begin
        m     = shuffle(CRD_W'(r_ec.x), CRD_W'(r_ec.y));
        bad   = 1'b0;
        res_f = r_ec.res;
        if (r_ec.op) begin
            bad   = !(r_ec.bh < 4'd12 && r_ec.x >= 0 && r_ec.x < ns
                      && r_ec.y >= 0 && r_ec.y < ns);
            res_f = (t_wide'(r_ec.bh) <<< ord2) | t_wide'(m);
        end
        err_f           = r_ec.err || bad || res_f < 0 || res_f >= npix;
        n_rsp.error     = err_f;
        n_rsp.pixel_out = err_f ? '0 : PIX_W'(res_f);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_ec_vld;
        end
        if (adv) begin
            r_rsp <= n_rsp;
        end
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nested/ring pixel converter. A built-in
// predictor works out each conversion from the accepted request. Results
// are compared in order. The run walks through several resolution orders
// and several patterns of request gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import hnr_pkg::*;

    // Predicts conversions at one resolution order and holds the results
    // still owed by the converter, oldest first.
    class pixel_scoreboard;
        logic [ORD_W-1:0] order;
        t_rsp             owed_rsp[$];
        int               failures;

        function new();
            order    = NSIDE_LOG2_RST;
            failures = 0;
        endfunction

        function longint isqrt(longint v);
            longint r;
            longint b;
            r = 0;
            b = longint'(1) << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // Ring inside a polar cap, counted from its pole
        function longint cap_ring(longint p);
            longint r;
            r = (1 + isqrt(2 * p + 1)) / 2;
            if (r < 1) r = 1;
            while (r > 1 && 2 * r * (r - 1) > p) r--;
            while (2 * r * (r + 1) <= p) r++;
            return r;
        endfunction

        function longint face_to_ring(longint bh, longint x, longint y, longint ns);
            longint frow, ring, idx, ri, s, f2;
            frow = bh / 4;
            ring = (frow + 2) * ns - (x + y) - 1;
            if (ring < 1 || ring >= 4 * ns) return -1;
            if (ring <= ns) begin
                idx = (ns - 1 - y) + (bh % 4) * ring + ring * (ring - 1) * 2;
            end else if (ring >= 3 * ns) begin
                ri  = 4 * ns - ring;
                idx = (ri - 1) - x + (3 - (bh % 4)) * ri + ri * (ri - 1) * 2;
                idx = 12 * ns * ns - 1 - idx;
            end else begin
                s   = (ring - ns) % 2;
                f2  = 2 * (bh % 4) - (frow % 2) + 1;
                idx = (f2 * ns + (x - y) + s) / 2;
                idx += ns * (ns - 1) * 2 + ns * 4 * (ring - ns);
                // face 4 straddles longitude zero
                if (bh == 4 && y > x) idx += 4 * ns - 1;
            end
            return idx;
        endfunction

        function void ring_to_face(longint p, longint ns,
                                   output longint bh, output longint x,
                                   output longint y);
            longint ring, lon, q, pp, ri, panel, ind, b, frow, f2, s, vv, hh;
            bit     bl, tl, wrap;
            wrap = 0;
            if (p < 2 * ns * (ns - 1)) begin
                ring = cap_ring(p);
                lon  = p - 2 * ring * (ring - 1);
            end else if (p < 2 * ns * (ns - 1) + 8 * ns * ns) begin
                q    = p - 2 * ns * (ns - 1);
                ring = ns + q / (4 * ns);
                lon  = q % (4 * ns);
            end else begin
                pp   = 12 * ns * ns - 1 - p;
                ri   = cap_ring(pp);
                ring = 4 * ns - ri;
                lon  = 4 * ri - 1 - (pp - 2 * ri * (ri - 1));
            end
            if (ring <= ns) begin
                bh = lon / ring;
                y  = ns - 1 - (lon % ring);
                x  = (bh / 4 + 2) * ns - ring - 1 - y;
            end else if (ring < 3 * ns) begin
                panel = lon / ns;
                ind   = lon % ns;
                bl    = ind < (ring - ns + 1) / 2;
                tl    = ind < (3 * ns - ring + 1) / 2;
                if (!bl && tl) b = panel;
                else if (bl && !tl) b = 8 + panel;
                else if (bl && tl) b = 4 + panel;
                else begin
                    b = 4 + (panel + 1) % 4;
                    if (b == 4) begin
                        lon  = lon - (4 * ns - 1);
                        wrap = 1;
                    end
                end
                frow = b / 4;
                f2   = 2 * (b % 4) - (frow % 2) + 1;
                s    = (ring - ns) % 2;
                vv   = (frow + 2) * ns - ring - 1;
                hh   = 2 * lon - s - f2 * ns;
                if (wrap) hh--;
                x = (vv + hh) / 2;
                y = (vv - hh) / 2;
                // parity mismatch: shift by one and redo
                if (vv != x + y || hh != x - y) begin
                    hh++;
                    x = (vv + hh) / 2;
                    y = (vv - hh) / 2;
                end
                bh = b;
            end else begin
                ri  = 4 * ns - ring;
                bh  = 8 + lon / ri;
                ind = lon - (bh % 4) * ri;
                y   = (ri - 1) - ind;
                x   = (bh / 4 + 2) * ns - ring - 1 - y;
            end
        endfunction

        function t_rsp convert(t_req rq);
            int     ord;
            longint ns, ns2, npix, p, res, bh, x, y, m, idx;
            t_rsp   r;
            ord  = (order > MAX_ORDER) ? MAX_ORDER : int'(order);
            ns   = longint'(1) << ord;
            ns2  = ns * ns;
            npix = 12 * ns2;
            p    = longint'(rq.pixel_in);
            res  = -1;
            if (p < npix) begin
                if (!rq.op) begin
                    bh  = p >> (2 * ord);
                    idx = p & (ns2 - 1);
                    x   = 0;
                    y   = 0;
                    for (int i = 0; i < ord; i++) begin
                        x |= ((idx >> (2 * i)) & 1) << i;
                        y |= ((idx >> (2 * i + 1)) & 1) << i;
                    end
                    res = face_to_ring(bh, x, y, ns);
                end else begin
                    ring_to_face(p, ns, bh, x, y);
                    if (bh >= 0 && bh < 12 && x >= 0 && x < ns && y >= 0 && y < ns) begin
                        m = 0;
                        for (int i = 0; i < ord; i++) begin
                            m |= ((x >> i) & 1) << (2 * i);
                            m |= ((y >> i) & 1) << (2 * i + 1);
                        end
                        res = bh * ns2 + m;
                    end
                end
            end
            if (res < 0 || res >= npix) begin
                r.pixel_out = '0;
                r.error     = 1'b1;
            end else begin
                r.pixel_out = res[PIX_W-1:0];
                r.error     = 1'b0;
            end
            return r;
        endfunction

        function void note_request(t_req rq);
            owed_rsp.insert(owed_rsp.size(), convert(rq));
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (owed_rsp.size() == 0) begin
                $display("%0t: unexpected result pixel_out=%0d error=%0b",
                         $time, got.pixel_out, got.error);
                failures++;
                return;
            end
            want = owed_rsp.pop_front();
            if (got.pixel_out !== want.pixel_out) begin
                $display("%0t: pixel_out mismatch expected %0d actual %0d",
                         $time, want.pixel_out, got.pixel_out);
                failures++;
            end
            if (got.error !== want.error) begin
                $display("%0t: error flag mismatch expected %0b actual %0b",
                         $time, want.error, got.error);
                failures++;
            end
        endfunction
    endclass

    localparam int DRAIN_CYCLES = 30;      // covers the pipeline depth, plus margin
    localparam int STUCK_LIMIT  = 20000;   // cycles with no request or result moving

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    t_req                i_req;
    logic                o_valid;
    logic                i_ready;
    t_rsp                o_rsp;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    pixel_scoreboard board;
    int              send_gap_pct;
    int              recv_stall_pct;
    int              stuck_cycles;

    healpix_nest_ring_converter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Note each accepted request, check each accepted result, and redraw
    // the result-side stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) board.note_request(i_req);
        if (i_rst_n && o_valid && i_ready) board.check_result(o_rsp);
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Present one request, with random gaps before it, and hold until taken
    task automatic send_request(input logic op, input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req.op       <= op;
        i_req.pixel_in <= pix;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid, let every owed result arrive, then let the pipe go quiet
    task automatic drain_pipe();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.owed_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup phase, then access phase
    task automatic write_order(input logic [ORD_W-1:0] ord);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({REG_NSIDE_LOG2, 2'b00});
        pwdata  <= DATA_W'(ord);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.order = ord;
    endtask

    // Seam pixels: range ends, cap/belt edges, ends of the face at longitude zero
    function automatic logic [PIX_W-1:0] seam_pixel(input int ord, input int pick);
        longint ns, ns2, cap, belt, v;
        ns   = longint'(1) << ord;
        ns2  = ns * ns;
        cap  = 2 * ns * (ns - 1);
        belt = cap + 8 * ns2;
        case (pick)
            0:  v = 0;
            1:  v = 1;
            2:  v = 12 * ns2 - 1;
            3:  v = 12 * ns2;
            4:  v = (longint'(1) << PIX_W) - 1;
            5:  v = cap - 1;
            6:  v = cap;
            7:  v = belt - 1;
            8:  v = belt;
            9:  v = 4 * ns2;
            default: v = 5 * ns2 - 1;
        endcase
        if (v < 0) v = 0;
        return v[PIX_W-1:0];
    endfunction

    initial begin
        logic [ORD_W-1:0] phase_order[12];
        int               gap_pct[4];
        int               stall_pct[4];
        int               ord;
        longint           npix;
        int               pick;
        logic [PIX_W-1:0] pix;

        phase_order    = '{4'd10, 4'd0, 4'd13, 4'd15, 4'd1, 4'd2,
                           4'd3, 4'd4, 4'd5, 4'd14, 4'd7, 4'd12};
        gap_pct        = '{0, 82, 0, 35};
        stall_pct      = '{0, 0, 82, 35};
        board          = new();
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_req          = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (phase_order[ph]) begin
            // the first phase runs at the reset order, untouched
            if (ph != 0) write_order(phase_order[ph]);
            ord            = (phase_order[ph] > MAX_ORDER) ? MAX_ORDER : phase_order[ph];
            npix           = 12 * (longint'(1) << (2 * ord));
            send_gap_pct   = gap_pct[ph % 4];
            recv_stall_pct = stall_pct[ph % 4];

            // Directed: every seam both ways, at the reset order only
            if (ph == 0) begin
                for (int k = 0; k < 11; k++) begin
                    send_request(1'b0, seam_pixel(ord, k));
                    send_request(1'b1, seam_pixel(ord, k));
                end
            end

            // Random: mostly in range, some seams, some raw 30-bit noise
            for (int n = 0; n < 100; n++) begin
                pick = $urandom_range(99);
                if (pick < 70) pix = PIX_W'($urandom_range(32'(npix - 1)));
                else if (pick < 85) pix = seam_pixel(ord, $urandom_range(10));
                else pix = PIX_W'($urandom);
                send_request(1'($urandom_range(1)), pix);
            end
            drain_pipe();
        end

        if (board.failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/hnr_pkg.sv
rtl/core/healpix_nest_ring_converter.sv
tb/sv/tb_top.sv
